// ----- sv/fqr_pkg.sv -----
// Package for the fair-queue rank engine: transaction types, field widths,
// default parameter values, operation and status codes. No dependencies.
package fqr_pkg;

  localparam int unsigned FLOWS_DEF    = 1024;
  localparam int unsigned TAG_BITS_DEF = 48;

  localparam int unsigned FLOW_ID_W = 10;
  localparam int unsigned PKT_LEN_W = 16;
  localparam int unsigned RANK_W    = 48;
  localparam int unsigned BYTES_W   = 32;
  localparam int unsigned PEND_W    = 16;
  localparam int unsigned QUANTUM_W = 16;

  localparam logic [QUANTUM_W-1:0] QUANTUM_RESET = 16'd1514;

  // Configuration port: byte address, one 32-bit register at offset 0.
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic        REG_QUANTUM = 1'b0;  // register index, paddr bit 2

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_UNDERFLOW = 1'b1;

  typedef struct packed {
    logic                 op;
    logic [FLOW_ID_W-1:0] flow_id;
    logic [PKT_LEN_W-1:0] pkt_len;
    logic [RANK_W-1:0]    dequeued_rank;
  } in_item_t;

  typedef struct packed {
    logic [RANK_W-1:0]  rank;
    logic [BYTES_W-1:0] flow_bytes;
    logic               status;
  } out_item_t;

endpackage

// ----- sv/fqr_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Self-contained; used for the flow table of the rank engine.
module fqr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/fair_queue_rank_engine_top.sv -----
// Fair-queue rank engine, top level. Depends on fqr_pkg and fqr_ram.
// A transaction's flow-table row is read at accept in ST_IDLE, then updated,
// written back and its result registered in ST_EXEC; no new transaction is
// taken until ST_EXEC is left, which a stalled output can hold. Reset: the
// virtual clock and quantum reset at once; the flow table is then cleared by
// a pass over all FLOWS rows, during which in_stall_o stays high.
module fair_queue_rank_engine_top #(
  parameter int unsigned FLOWS    = fqr_pkg::FLOWS_DEF,
  parameter int unsigned TAG_BITS = fqr_pkg::TAG_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  fqr_pkg::in_item_t             in_data_i,
  // Output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output fqr_pkg::out_item_t            out_data_o,
  // Configuration port
  input  logic                          psel_i,
  input  logic                          penable_i,
  input  logic                          pwrite_i,
  input  logic [fqr_pkg::PADDR_W-1:0]   paddr_i,
  input  logic [fqr_pkg::PDATA_W-1:0]   pwdata_i,
  output logic [fqr_pkg::PDATA_W-1:0]   prdata_o,
  output logic                          pready_o
);

  import fqr_pkg::*;

  localparam int unsigned FIDX_W = $clog2(FLOWS);

  // One flow table row holds all per-flow state, so a single memory access
  // reads or writes a whole flow.
  typedef struct packed {
    logic [PEND_W-1:0]   pending;
    logic [BYTES_W-1:0]  bytes;
    logic [TAG_BITS-1:0] finish;
    logic [TAG_BITS-1:0] grace;
  } flow_entry_t;

  localparam int unsigned ENTRY_W = $bits(flow_entry_t);

  // Clearing the table after reset, waiting for a transaction, and the state
  // in which the flow's row has been read and is updated.
  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_EXEC  = 3'b100
  } state_e;

  state_e                state_q, state_d;
  logic [FIDX_W-1:0]     clr_idx_q, clr_idx_d;
  logic [QUANTUM_W-1:0]  quantum_q;
  logic [TAG_BITS-1:0]   vclk_q, vclk_d;
  in_item_t              item_q;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_data_q, out_data_d;

  logic                  in_accept;
  logic                  cfg_write;
  logic                  exec_done;
  logic                  in_range;

  logic                  ram_we;
  logic [FIDX_W-1:0]     ram_waddr;
  flow_entry_t           ram_wdata;
  flow_entry_t           ram_rdata;
  logic [ENTRY_W-1:0]    ram_rdata_raw;

  // Enqueue and dequeue arithmetic.
  logic [TAG_BITS-1:0]   q_ext;
  logic                  restart;
  logic [TAG_BITS-1:0]   restart_rank;
  logic [TAG_BITS-1:0]   prio;
  logic [BYTES_W-1:0]    bytes_base;
  logic [BYTES_W-1:0]    bytes_enq;
  logic [PEND_W-1:0]     pend_enq;
  logic [PEND_W-1:0]     pend_deq;
  logic                  underflow;
  flow_entry_t           upd_entry;

  // ------------------------------------------------------------------------
  // Configuration port. Writes land in the access phase; pready is always
  // high, so every transaction finishes in its first access phase.
  // ------------------------------------------------------------------------
  assign pready_o  = 1'b1;
  assign cfg_write = psel_i && penable_i && pwrite_i && (paddr_i[2] == REG_QUANTUM);
  assign prdata_o  = (paddr_i[2] == REG_QUANTUM) ? PDATA_W'(quantum_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quantum_q <= QUANTUM_RESET;
    end else if (cfg_write) begin
      quantum_q <= pwdata_i[QUANTUM_W-1:0];
    end
  end

  // ------------------------------------------------------------------------
  // Handshakes. A new transaction is taken only in the idle state; the
  // output register lets the next transaction in while a result waits.
  // ------------------------------------------------------------------------
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && (state_q == ST_IDLE);
  assign exec_done  = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);
  assign in_range   = (32'(item_q.flow_id) < FLOWS);

  // ------------------------------------------------------------------------
  // Row update. The row read at accept is valid during ST_EXEC and holds,
  // since no further read is issued while the result is blocked.
  // ------------------------------------------------------------------------
  assign ram_rdata = flow_entry_t'(ram_rdata_raw);

  always_comb begin
    q_ext        = TAG_BITS'(quantum_q);
    // A flow restarts when it has nothing queued and its grace time is over.
    restart      = (ram_rdata.pending == '0) && (vclk_q >= ram_rdata.grace);
    // Restart rank is the virtual clock less the quantum, clamped at zero.
    restart_rank = (vclk_q >= q_ext) ? (vclk_q - q_ext) : '0;
    prio         = restart ? restart_rank : ram_rdata.finish;
    bytes_base   = restart ? '0 : ram_rdata.bytes;
    bytes_enq    = bytes_base + BYTES_W'(item_q.pkt_len);
    pend_enq     = (ram_rdata.pending == '1) ? ram_rdata.pending
                                             : ram_rdata.pending + PEND_W'(1);
    underflow    = (ram_rdata.pending == '0);
    pend_deq     = underflow ? ram_rdata.pending : ram_rdata.pending - PEND_W'(1);

    upd_entry = ram_rdata;
    out_data_d.rank       = '0;
    out_data_d.flow_bytes = '0;
    out_data_d.status     = STATUS_OK;

    if (item_q.op == OP_ENQUEUE) begin
      upd_entry.pending = pend_enq;
      upd_entry.bytes   = bytes_enq;
      upd_entry.finish  = prio + TAG_BITS'(item_q.pkt_len);
      upd_entry.grace   = vclk_q + q_ext;
      if (in_range) begin
        out_data_d.rank       = RANK_W'(prio);
        out_data_d.flow_bytes = bytes_enq;
      end
    end else begin
      upd_entry.pending = pend_deq;
      if (in_range) begin
        out_data_d.flow_bytes = ram_rdata.bytes;
        out_data_d.status     = underflow ? STATUS_UNDERFLOW : STATUS_OK;
      end else begin
        out_data_d.status     = STATUS_UNDERFLOW;
      end
    end
  end

  // The dequeue report moves the virtual clock whether or not the flow
  // index lies inside the table.
  always_comb begin
    vclk_d = vclk_q;
    if (exec_done && (item_q.op == OP_DEQUEUE)) begin
      vclk_d = TAG_BITS'(item_q.dequeued_rank);
    end
  end

  // ------------------------------------------------------------------------
  // Flow table write port: zeros during the clearing pass, otherwise the
  // updated row when a transaction completes on an existing flow.
  // ------------------------------------------------------------------------
  always_comb begin
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_q;
      ram_wdata = '0;
    end else begin
      ram_we    = exec_done && in_range;
      ram_waddr = FIDX_W'(item_q.flow_id);
      ram_wdata = upd_entry;
    end
  end

  fqr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (FLOWS)
  ) u_flow_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (in_accept),
    .raddr_i (FIDX_W'(in_data_i.flow_id)),
    .rdata_o (ram_rdata_raw)
  );

  // ------------------------------------------------------------------------
  // Sequencer.
  // ------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    clr_idx_d = clr_idx_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_idx_d = clr_idx_q + FIDX_W'(1);
        if (clr_idx_q == FIDX_W'(FLOWS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_done) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (exec_done) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      vclk_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_idx_q   <= clr_idx_d;
      vclk_q      <= vclk_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_data_i;
    end
    if (exec_done) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
